[hdl/ghcv_pkg.sv]
// ghcv_pkg: shared types and constants of the gradient hough circle voter
// no dependencies; used by ghcv_offset, ghcv_table and the top level
package ghcv_pkg;

  localparam int unsigned AR_W    = 7;   // |trial radius|, up to 66
  localparam int unsigned GRAD_W  = 10;  // |X| or |Y|, up to 1020
  localparam int unsigned SUM_W   = 21;  // X*X + Y*Y, up to 2080800
  localparam int unsigned QUO_W   = 29;  // r^2*A^2*65536/S stays below 2^29
  localparam int unsigned OFF_W   = 15;  // q8 offset, up to 256*66
  localparam int unsigned COORD_W = 10;
  localparam int unsigned CNT_W   = 16;

  localparam logic [SUM_W-1:0] GRAD_SQ_LIM = SUM_W'(200 * 200);
  localparam logic [CNT_W-1:0] CNT_MAX     = '1;

  // configuration register indexes
  localparam logic [1:0] REG_RADIUS   = 2'd0;
  localparam logic [1:0] REG_RANGE    = 2'd1;
  localparam logic [1:0] REG_MIN_CONF = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [CNT_W-1:0]          count;
  } entry_t;

endpackage

[hdl/ghcv_offset.sv]
// ghcv_offset: sequential q8 offset unit, isqrt(r^2 * a^2 * 65536 / s)
// multiply, restoring divide (one bit a cycle), digit-serial square root
// depends on ghcv_pkg
module ghcv_offset (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [ghcv_pkg::AR_W-1:0]        ar,
  input  logic [ghcv_pkg::GRAD_W-1:0]      a,
  input  logic [ghcv_pkg::SUM_W-1:0]       s,
  output logic                             done,
  output logic [ghcv_pkg::OFF_W-1:0]       off
);

  typedef enum logic [4:0] {
    O_IDLE = 5'b00001,
    O_MUL1 = 5'b00010,
    O_MUL2 = 5'b00100,
    O_DIV  = 5'b01000,
    O_SQRT = 5'b10000
  } ostate_t;

  localparam int unsigned AR2_W = 2 * ghcv_pkg::AR_W;
  localparam int unsigned A2_W  = 2 * ghcv_pkg::GRAD_W;
  localparam int unsigned PR_W  = AR2_W + A2_W;
  localparam int unsigned QW    = ghcv_pkg::QUO_W;
  localparam int unsigned SW    = ghcv_pkg::SUM_W;

  ostate_t                 state_r, state_nxt;
  logic [ghcv_pkg::AR_W-1:0]   ar_r;
  logic [ghcv_pkg::GRAD_W-1:0] a_r;
  logic [SW-1:0]           s_r;
  logic [AR2_W-1:0]        ar2_r;
  logic [A2_W-1:0]         a2_r;
  logic [SW-1:0]           rem_r, rem_nxt;
  logic [QW-1:0]           dq_r, dq_nxt;
  logic [4:0]              cnt_r, cnt_nxt;
  logic [QW-1:0]           v_r, v_nxt;
  logic [QW-1:0]           res_r, res_nxt;
  logic [QW-1:0]           bit_r, bit_nxt;
  logic                    done_r, done_nxt;
  logic [ghcv_pkg::OFF_W-1:0] off_r, off_nxt;

  logic [PR_W-1:0]         prod;
  logic [SW:0]             trial;
  logic                    qbit;
  logic [QW:0]             sq_sum;
  logic                    sq_take;

  assign prod    = PR_W'(ar2_r) * PR_W'(a2_r);
  assign trial   = {rem_r, dq_r[QW-1]};
  assign qbit    = (trial >= {1'b0, s_r});
  assign sq_sum  = {1'b0, res_r} + {1'b0, bit_r};
  assign sq_take = ({1'b0, v_r} >= sq_sum);

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    dq_nxt    = dq_r;
    cnt_nxt   = cnt_r;
    v_nxt     = v_r;
    res_nxt   = res_r;
    bit_nxt   = bit_r;
    done_nxt  = 1'b0;
    off_nxt   = off_r;
    case (state_r)
      O_IDLE: begin
        if (start) begin
          state_nxt = O_MUL1;
        end
      end
      O_MUL1: begin
        state_nxt = O_MUL2;
      end
      O_MUL2: begin
        // numerator is prod << 16; its top bits are already below s
        rem_nxt   = SW'(prod[PR_W-1:QW-16]);
        dq_nxt    = {prod[QW-17:0], 16'b0};
        cnt_nxt   = 5'(QW - 1);
        state_nxt = O_DIV;
      end
      O_DIV: begin
        rem_nxt = qbit ? SW'(trial - {1'b0, s_r}) : SW'(trial);
        dq_nxt  = {dq_r[QW-2:0], qbit};
        if (cnt_r == '0) begin
          v_nxt     = {dq_r[QW-2:0], qbit};
          res_nxt   = '0;
          bit_nxt   = QW'(1) << (QW - 1);
          cnt_nxt   = 5'(QW / 2);
          state_nxt = O_SQRT;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      O_SQRT: begin
        if (sq_take) begin
          v_nxt   = v_r - sq_sum[QW-1:0];
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (cnt_r == '0) begin
          off_nxt   = res_nxt[ghcv_pkg::OFF_W-1:0];
          done_nxt  = 1'b1;
          state_nxt = O_IDLE;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      default: begin
        state_nxt = O_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= O_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == O_IDLE && start) begin
      ar_r <= ar;
      a_r  <= a;
      s_r  <= s;
    end
    if (state_r == O_MUL1) begin
      ar2_r <= AR2_W'(ar_r) * AR2_W'(ar_r);
      a2_r  <= A2_W'(a_r) * A2_W'(a_r);
    end
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    cnt_r <= cnt_nxt;
    v_r   <= v_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    off_r <= off_nxt;
  end

  assign done = done_r;
  assign off  = off_r;

endmodule

[hdl/ghcv_table.sv]
// ghcv_table: candidate table, one write port and one registered read port
// depends on ghcv_pkg for the entry layout
module ghcv_table #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          re,
  input  logic [$clog2(DEPTH)-1:0]      raddr,
  output ghcv_pkg::entry_t              rdata,
  input  logic                          we,
  input  logic [$clog2(DEPTH)-1:0]      waddr,
  input  ghcv_pkg::entry_t              wdata
);

  ghcv_pkg::entry_t mem [DEPTH];
  ghcv_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/gradient_hough_circle_voter.sv]
// gradient_hough_circle_voter: top level, control sequencer and registers
// depends on ghcv_pkg, ghcv_offset and ghcv_table
//
// usage
//   input: an item is transferred at a clock edge with start high and busy low.
//   in_mode 0 votes with the pixel, in_mode 1 asks for the end-of-frame report.
//   output: the report appears for one cycle with out_valid high; it cannot be
//   held off, the receiver must take it then. votes give no output.
//   config: cfg_we writes cfg_data into register cfg_index (0 radius, 1 radius
//   range, 2 min confidence) with no wait; write only while busy is low.
// sequencing
//   a vote pixel that is off the image, or arrives with the table full, is
//   dropped in the transfer cycle. otherwise gradient, square sum and
//   threshold follow in turn; each trial radius runs the offset unit twice
//   (major then minor; multiply, 29-step divide, 15-step root, done), then
//   scans the table (registered read, then compare, per entry) up to a match
//   and appends the candidate on a miss, or ends the pixel if the table is
//   full. a report reads and compares every entry; out_valid is high in the
//   first cycle with busy low. the scan is serialized, so a table write
//   always lands before the next read of that entry and no forwarding is needed.
// reset
//   synchronous; empties the table (fill count), clears the previous centre,
//   loads radius 13, range 3, min confidence 1. table memory is not cleared.
module gradient_hough_circle_voter #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned IMAGE_SIZE  = 256,
  parameter int unsigned MAX_RADII   = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_mode,
  input  logic [7:0]                            in_pixel_x,
  input  logic [7:0]                            in_pixel_y,
  input  logic [7:0]                            in_gray_up_left,
  input  logic [7:0]                            in_gray_up,
  input  logic [7:0]                            in_gray_up_right,
  input  logic [7:0]                            in_gray_left,
  input  logic [7:0]                            in_gray_right,
  input  logic [7:0]                            in_gray_down_left,
  input  logic [7:0]                            in_gray_down,
  input  logic [7:0]                            in_gray_down_right,
  output logic                                  out_valid,
  output logic signed [9:0]                     out_center_x,
  output logic signed [9:0]                     out_center_y,
  output logic [15:0]                           out_confidence,
  output logic [8:0]                            out_candidate_count,
  output logic                                  out_used_previous,
  input  logic                                  cfg_we,
  input  logic [1:0]                            cfg_index,
  input  logic [15:0]                           cfg_data
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(TABLE_DEPTH);
  localparam logic [10:0]   IMG_LIM  = 11'(IMAGE_SIZE);
  localparam logic [4:0]    MAXR     = 5'(MAX_RADII);

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_GRAD   = 15'b000000000000010,
    S_SQ     = 15'b000000000000100,
    S_THR    = 15'b000000000001000,
    S_CAND   = 15'b000000000010000,
    S_MAJ    = 15'b000000000100000,
    S_MIN    = 15'b000000001000000,
    S_POS    = 15'b000000010000000,
    S_SC_RD  = 15'b000000100000000,
    S_SC_CMP = 15'b000001000000000,
    S_APPEND = 15'b000010000000000,
    S_NEXT   = 15'b000100000000000,
    S_RP_RD  = 15'b001000000000000,
    S_RP_CMP = 15'b010000000000000,
    S_RP_OUT = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [5:0]  radius_r;
  logic [3:0]  range_r;
  logic [15:0] min_conf_r;

  // captured item
  logic [7:0] px_r, py_r;
  logic [7:0] g_ul_r, g_u_r, g_ur_r, g_l_r, g_r_r, g_dl_r, g_d_r, g_dr_r;

  // gradient
  logic signed [10:0] gx_r, gy_r;
  logic [9:0]         ax_r, ay_r;
  logic [20:0]        s_r;
  logic               major_x_r;

  // trial radius loop
  logic [4:0]          n_cfg, half;
  logic [4:0]          i_r, i_nxt;
  logic signed [7:0]   rr;
  logic [6:0]          ar;
  logic [14:0]         maj_r, mnr_r;
  logic signed [9:0]   cand_x_r, cand_y_r;

  // table bookkeeping
  logic [CW-1:0]       ecount_r, ecount_nxt;
  logic [CW-1:0]       k_r, k_nxt;
  logic signed [9:0]   prev_x_r, prev_y_r;
  logic [15:0]         prev_c_r;
  logic signed [9:0]   best_x_r, best_y_r;
  logic [15:0]         best_c_r;

  // outputs
  logic                out_valid_r;
  logic signed [9:0]   ox_r, oy_r;
  logic [15:0]         oc_r;
  logic [8:0]          ocount_r;
  logic                oused_r;

  // offset unit
  logic        off_start, off_done;
  logic [9:0]  off_a;
  logic [14:0] off_val;

  // table port
  logic             tbl_re, tbl_we;
  logic [AW-1:0]    tbl_waddr;
  ghcv_pkg::entry_t tbl_rdata, tbl_wdata;

  logic accept;
  logic drop_pixel;
  logic match;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // pixels off the image or arriving on a full table never start
  assign drop_pixel = ({3'b0, in_pixel_x} >= IMG_LIM) || ({3'b0, in_pixel_y} >= IMG_LIM) ||
                      (ecount_r >= DEPTH_C);

  // trial radii: r = radius - half + i, range clamped first
  assign n_cfg = ({1'b0, range_r} > MAXR) ? MAXR : {1'b0, range_r};
  assign half  = n_cfg >> 1;
  assign rr    = $signed({2'b0, radius_r}) - $signed({3'b0, half}) + $signed({3'b0, i_r});
  assign ar    = rr[7] ? 7'(-rr) : 7'(rr);

  // major offset first, then minor
  assign off_start = (state_r == S_CAND) || ((state_r == S_MAJ) && off_done);
  assign off_a     = ((state_r == S_CAND) == major_x_r) ? ax_r : ay_r;

  ghcv_offset u_offset (
    .clk   (clk),
    .rst_n (rst_n),
    .start (off_start),
    .ar    (ar),
    .a     (off_a),
    .s     (s_r),
    .done  (off_done),
    .off   (off_val)
  );

  ghcv_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .re    (tbl_re),
    .raddr (k_r[AW-1:0]),
    .rdata (tbl_rdata),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata)
  );

  assign match = (tbl_rdata.x == cand_x_r) && (tbl_rdata.y == cand_y_r);

  // candidate position from the pixel plus signed q8 offsets, truncated toward zero
  logic signed [15:0] maj_s, ox_s, oy_s;
  logic signed [17:0] vx, vy, nvx, nvy;
  logic signed [9:0]  cx, cy;

  always_comb begin
    maj_s = rr[7] ? -$signed({1'b0, maj_r}) : $signed({1'b0, maj_r});
    ox_s  = major_x_r ? maj_s : $signed({1'b0, mnr_r});
    oy_s  = major_x_r ? $signed({1'b0, mnr_r}) : maj_s;
    vx    = $signed({2'b0, px_r, 8'b0}) + ((gx_r > 0) ? 18'(ox_s) : -18'(ox_s));
    vy    = $signed({2'b0, py_r, 8'b0}) + ((gy_r < 0) ? 18'(oy_s) : -18'(oy_s));
    nvx   = -vx;
    nvy   = -vy;
    cx    = vx[17] ? -10'(nvx >>> 8) : 10'(vx >>> 8);
    cy    = vy[17] ? -10'(nvy >>> 8) : 10'(vy >>> 8);
  end

  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    k_nxt      = k_r;
    ecount_nxt = ecount_r;
    tbl_re     = 1'b0;
    tbl_we     = 1'b0;
    tbl_waddr  = k_r[AW-1:0];
    tbl_wdata  = tbl_rdata;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_mode) begin
            k_nxt     = '0;
            state_nxt = S_RP_RD;
          end else if (!drop_pixel) begin
            state_nxt = S_GRAD;
          end
        end
      end
      S_GRAD: begin
        state_nxt = S_SQ;
      end
      S_SQ: begin
        state_nxt = S_THR;
      end
      S_THR: begin
        if (s_r > ghcv_pkg::GRAD_SQ_LIM && n_cfg != '0) begin
          i_nxt     = n_cfg - 5'd1;
          state_nxt = S_CAND;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CAND: begin
        state_nxt = S_MAJ;
      end
      S_MAJ: begin
        if (off_done) begin
          state_nxt = S_MIN;
        end
      end
      S_MIN: begin
        if (off_done) begin
          state_nxt = S_POS;
        end
      end
      S_POS: begin
        k_nxt     = '0;
        state_nxt = S_SC_RD;
      end
      S_SC_RD: begin
        if (k_r < ecount_r) begin
          tbl_re    = 1'b1;
          state_nxt = S_SC_CMP;
        end else begin
          state_nxt = S_APPEND;
        end
      end
      S_SC_CMP: begin
        if (match) begin
          // raise the matching entry, saturating
          tbl_we          = 1'b1;
          tbl_wdata.count = (tbl_rdata.count == ghcv_pkg::CNT_MAX) ?
                            tbl_rdata.count : tbl_rdata.count + 16'd1;
          state_nxt       = S_NEXT;
        end else begin
          k_nxt     = k_r + CW'(1);
          state_nxt = S_SC_RD;
        end
      end
      S_APPEND: begin
        if (ecount_r >= DEPTH_C) begin
          // table full ends this pixel
          state_nxt = S_IDLE;
        end else begin
          tbl_we          = 1'b1;
          tbl_waddr       = ecount_r[AW-1:0];
          tbl_wdata.x     = cand_x_r;
          tbl_wdata.y     = cand_y_r;
          tbl_wdata.count = 16'd1;
          ecount_nxt      = ecount_r + CW'(1);
          state_nxt       = S_NEXT;
        end
      end
      S_NEXT: begin
        if (i_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          i_nxt     = i_r - 5'd1;
          state_nxt = S_CAND;
        end
      end
      S_RP_RD: begin
        if (k_r < ecount_r) begin
          tbl_re    = 1'b1;
          state_nxt = S_RP_CMP;
        end else begin
          state_nxt = S_RP_OUT;
        end
      end
      S_RP_CMP: begin
        k_nxt     = k_r + CW'(1);
        state_nxt = S_RP_RD;
      end
      S_RP_OUT: begin
        ecount_nxt = '0;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ecount_r    <= '0;
      out_valid_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_c_r    <= '0;
      radius_r    <= 6'd13;
      range_r     <= 4'd3;
      min_conf_r  <= 16'd1;
    end else begin
      state_r     <= state_nxt;
      ecount_r    <= ecount_nxt;
      out_valid_r <= (state_r == S_RP_OUT);
      if (state_r == S_RP_OUT) begin
        if (best_c_r < min_conf_r) begin
          prev_x_r <= prev_x_r;
          prev_y_r <= prev_y_r;
          prev_c_r <= prev_c_r;
        end else begin
          prev_x_r <= best_x_r;
          prev_y_r <= best_y_r;
          prev_c_r <= best_c_r;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          ghcv_pkg::REG_RADIUS:   radius_r   <= cfg_data[5:0];
          ghcv_pkg::REG_RANGE:    range_r    <= cfg_data[3:0];
          ghcv_pkg::REG_MIN_CONF: min_conf_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    k_r <= k_nxt;
    if (accept) begin
      px_r   <= in_pixel_x;
      py_r   <= in_pixel_y;
      g_ul_r <= in_gray_up_left;
      g_u_r  <= in_gray_up;
      g_ur_r <= in_gray_up_right;
      g_l_r  <= in_gray_left;
      g_r_r  <= in_gray_right;
      g_dl_r <= in_gray_down_left;
      g_d_r  <= in_gray_down;
      g_dr_r <= in_gray_down_right;
    end
    if (state_r == S_GRAD) begin
      gx_r <= $signed({1'b0, 10'(g_ur_r) + {1'b0, g_r_r, 1'b0} + 10'(g_dr_r)}) -
              $signed({1'b0, 10'(g_ul_r) + {1'b0, g_l_r, 1'b0} + 10'(g_dl_r)});
      gy_r <= $signed({1'b0, 10'(g_ul_r) + {1'b0, g_u_r, 1'b0} + 10'(g_ur_r)}) -
              $signed({1'b0, 10'(g_dl_r) + {1'b0, g_d_r, 1'b0} + 10'(g_dr_r)});
    end
    if (state_r == S_SQ) begin
      s_r       <= 21'(20'(ax_r) * 20'(ax_r)) + 21'(20'(ay_r) * 20'(ay_r));
      major_x_r <= (ax_r > ay_r);
    end
    if (state_r == S_MAJ && off_done) begin
      maj_r <= off_val;
    end
    if (state_r == S_MIN && off_done) begin
      mnr_r <= off_val;
    end
    if (state_r == S_POS) begin
      cand_x_r <= cx;
      cand_y_r <= cy;
    end
    if (accept) begin
      best_x_r <= '0;
      best_y_r <= '0;
      best_c_r <= '0;
    end else if (state_r == S_RP_CMP && tbl_rdata.count > best_c_r) begin
      // strictly greater keeps the first of equal counts
      best_x_r <= tbl_rdata.x;
      best_y_r <= tbl_rdata.y;
      best_c_r <= tbl_rdata.count;
    end
    if (state_r == S_RP_OUT) begin
      ocount_r <= 9'(ecount_r);
      if (best_c_r < min_conf_r) begin
        ox_r    <= prev_x_r;
        oy_r    <= prev_y_r;
        oc_r    <= prev_c_r;
        oused_r <= 1'b1;
      end else begin
        ox_r    <= best_x_r;
        oy_r    <= best_y_r;
        oc_r    <= best_c_r;
        oused_r <= 1'b0;
      end
    end
  end

  assign ax_r = gx_r[10] ? 10'(-gx_r) : 10'(gx_r);
  assign ay_r = gy_r[10] ? 10'(-gy_r) : 10'(gy_r);

  assign out_valid           = out_valid_r;
  assign out_center_x        = ox_r;
  assign out_center_y        = oy_r;
  assign out_confidence      = oc_r;
  assign out_candidate_count = ocount_r;
  assign out_used_previous   = oused_r;

endmodule

[hdl/ghcv_checker.sv]
// ghcv_checker: port-level checks of the circle voter, bound to the top level
// depends on gradient_hough_circle_voter port names only
module ghcv_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_mode,
  input logic out_valid
);

  // a report is a single-cycle strobe
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid held longer than one cycle");

  // no report straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // a vote transfer never produces a report next cycle
  a_vote_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_mode) |=> !out_valid)
    else $error("report after a vote transfer");

  // a report transfer always occupies the block
  a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode) |=> busy)
    else $error("report transfer did not start");

  // the report is shown only once the block is free again
  a_report_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("report while busy");

endmodule

bind gradient_hough_circle_voter ghcv_checker u_ghcv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_mode   (in_mode),
  .out_valid (out_valid)
);

[tb/gradient_hough_circle_voter_test.sv]
// gradient_hough_circle_voter_test: self-checking testbench of the circle voter
// depends on ghcv_pkg and gradient_hough_circle_voter; predicts every report
`timescale 1ns / 1ps

module gradient_hough_circle_voter_test;

  localparam int DEPTH = 256;
  localparam int RADII = 8;

  // one input item as it sits on the in_ ports
  typedef struct packed {
    logic       mode;
    logic [7:0] px, py;
    logic [7:0] ul, u, ur, l, r, dl, d, dr;
  } pixel_item_t;

  // one end-of-frame report
  typedef struct packed {
    logic signed [9:0] cx, cy;
    logic [15:0]       conf;
    logic [8:0]        cnt;
    logic              used;
  } report_t;

  logic clk, rst_n, start, busy, in_mode, out_valid, out_used_previous, cfg_we;
  logic [7:0] in_pixel_x, in_pixel_y, in_gray_up_left, in_gray_up, in_gray_up_right;
  logic [7:0] in_gray_left, in_gray_right, in_gray_down_left, in_gray_down;
  logic [7:0] in_gray_down_right;
  logic signed [9:0] out_center_x, out_center_y;
  logic [15:0] out_confidence, cfg_data;
  logic [8:0] out_candidate_count;
  logic [1:0] cfg_index;

  gradient_hough_circle_voter dut (.*);

  // predictor state: candidate centres, fill count, last report, registers
  int          cand_x [DEPTH];
  int          cand_y [DEPTH];
  int unsigned cand_votes [DEPTH];
  int unsigned fill;
  int          last_x, last_y;
  int unsigned last_votes;
  int unsigned radius_reg, range_reg, min_conf_reg;

  pixel_item_t pixel_q[$];   // items waiting for the driver
  report_t     report_q[$];  // reports the block still owes us
  int unsigned issued, taken;
  int unsigned idle_pct;
  bit          failed;

  // clock
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // exact integer square root, bit by bit
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // q8 offset along one axis: floor(256*r*a/sqrt(s))
  function automatic longint q8_step(longint unsigned ar, longint unsigned a,
                                     longint unsigned s);
    return longint'(int_sqrt((ar * ar * a * a * 65536) / s));
  endfunction

  // q8 to whole pixels, truncated toward zero
  function automatic int to_pixel(longint v);
    if (v >= 0) return int'(v >>> 8);
    return -int'((-v) >>> 8);
  endfunction

  // voting for one pixel: fills cand_* just like the block's table
  function automatic void cast_votes(pixel_item_t it);
    int gx, gy, rr, n, half, idx, k;
    longint unsigned ax, ay, s, ar;
    longint maj, mnr, ox, oy;
    int cx [RADII];
    int cy [RADII];
    bit major_x, hit;
    if (fill >= DEPTH) return;
    gx = (int'(it.ur) + 2 * int'(it.r) + int'(it.dr)) -
         (int'(it.ul) + 2 * int'(it.l) + int'(it.dl));
    gy = (int'(it.ul) + 2 * int'(it.u) + int'(it.ur)) -
         (int'(it.dl) + 2 * int'(it.d) + int'(it.dr));
    ax = gx < 0 ? -gx : gx;
    ay = gy < 0 ? -gy : gy;
    s = ax * ax + ay * ay;
    if (s <= 40000) return;
    major_x = ax > ay;
    n = range_reg > RADII ? RADII : range_reg;
    half = n / 2;
    for (int i = 0; i < n; i++) begin
      rr = int'(radius_reg) - half + i;
      ar = rr < 0 ? -rr : rr;
      maj = q8_step(ar, major_x ? ax : ay, s);
      mnr = q8_step(ar, major_x ? ay : ax, s);
      if (rr < 0) maj = -maj;
      ox = major_x ? maj : mnr;
      oy = major_x ? mnr : maj;
      cx[i] = to_pixel(longint'(it.px) * 256 + (gx > 0 ? ox : -ox));
      cy[i] = to_pixel(longint'(it.py) * 256 + (gy < 0 ? oy : -oy));
    end
    // largest radius first; a miss on a full table ends this pixel
    for (idx = n - 1; idx >= 0; idx--) begin
      hit = 0;
      for (k = 0; k < fill; k++) begin
        if (cand_x[k] == cx[idx] && cand_y[k] == cy[idx]) begin
          if (cand_votes[k] < 65535) cand_votes[k]++;
          hit = 1;
          break;
        end
      end
      if (!hit) begin
        if (fill >= DEPTH) break;
        cand_x[fill] = cx[idx];
        cand_y[fill] = cy[idx];
        cand_votes[fill] = 1;
        fill++;
      end
    end
  endfunction

  // end of frame: first best centre, else repeat the last one
  function automatic report_t frame_report();
    report_t rep;
    int bx, by;
    int unsigned bc;
    bit used;
    bx = 0;
    by = 0;
    bc = 0;
    used = 0;
    for (int k = 0; k < fill; k++) begin
      if (cand_votes[k] > bc) begin
        bx = cand_x[k];
        by = cand_y[k];
        bc = cand_votes[k];
      end
    end
    if (bc < min_conf_reg) begin
      bx = last_x;
      by = last_y;
      bc = last_votes;
      used = 1;
    end
    rep.cx = bx[9:0];
    rep.cy = by[9:0];
    rep.conf = bc[15:0];
    rep.cnt = fill[8:0];
    rep.used = used;
    last_x = bx;
    last_y = by;
    last_votes = bc;
    fill = 0;
    return rep;
  endfunction

  // driver: presents the next item at the falling edge once the last one transferred
  always @(negedge clk) begin
    pixel_item_t it;
    if (!rst_n) begin
      start <= 0;
    end else if (issued == taken) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        it = pixel_q.pop_front();
        issued <= issued + 1;
        start <= 1;
        in_mode <= it.mode;
        in_pixel_x <= it.px;
        in_pixel_y <= it.py;
        in_gray_up_left <= it.ul;
        in_gray_up <= it.u;
        in_gray_up_right <= it.ur;
        in_gray_left <= it.l;
        in_gray_right <= it.r;
        in_gray_down_left <= it.dl;
        in_gray_down <= it.d;
        in_gray_down_right <= it.dr;
      end else begin
        start <= 0;
      end
    end
  end

  // monitor: transfers, register writes and reports, all at the rising edge
  always @(posedge clk) begin
    pixel_item_t it;
    report_t got, want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          ghcv_pkg::REG_RADIUS:   radius_reg = cfg_data[5:0];
          ghcv_pkg::REG_RANGE:    range_reg = cfg_data[3:0];
          ghcv_pkg::REG_MIN_CONF: min_conf_reg = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        it = {in_mode, in_pixel_x, in_pixel_y, in_gray_up_left, in_gray_up,
              in_gray_up_right, in_gray_left, in_gray_right, in_gray_down_left,
              in_gray_down, in_gray_down_right};
        taken = taken + 1;
        if (it.mode) report_q.push_back(frame_report());
        else cast_votes(it);
      end
      if (out_valid) begin
        got = {out_center_x, out_center_y, out_confidence, out_candidate_count,
               out_used_previous};
        if (report_q.size() == 0) begin
          $display("%0t: report with none pending, got %h", $time, got);
          failed = 1;
        end else begin
          want = report_q.pop_front();
          if (got.cx !== want.cx)
            $display("%0t: center_x exp %0d got %0d", $time, want.cx, got.cx);
          if (got.cy !== want.cy)
            $display("%0t: center_y exp %0d got %0d", $time, want.cy, got.cy);
          if (got.conf !== want.conf)
            $display("%0t: confidence exp %0d got %0d", $time, want.conf, got.conf);
          if (got.cnt !== want.cnt)
            $display("%0t: candidate_count exp %0d got %0d", $time, want.cnt, got.cnt);
          if (got.used !== want.used)
            $display("%0t: used_previous exp %0d got %0d", $time, want.used, got.used);
          if (got !== want) failed = 1;
        end
      end
    end
  end

  // builds a vote item from a pixel and its eight neighbours
  function automatic pixel_item_t vote_item(int px, int py, int ul, int u, int ur,
                                            int l, int r, int dl, int d, int dr);
    return {1'b0, px[7:0], py[7:0], ul[7:0], u[7:0], ur[7:0], l[7:0], r[7:0],
            dl[7:0], d[7:0], dr[7:0]};
  endfunction

  function automatic pixel_item_t frame_end();
    pixel_item_t it;
    it = '0;
    it.mode = 1;
    it.px = 8'($urandom);
    it.py = 8'($urandom);
    return it;
  endfunction

  // random pixel: mostly a clean edge in a random direction, some noise
  function automatic pixel_item_t random_pixel();
    pixel_item_t it;
    logic [7:0] hi, lo;
    it = {1'b0, 80'($urandom) ^ {16'($urandom), 64'({$urandom, $urandom})}};
    if ($urandom_range(99) < 60) begin
      hi = 8'($urandom_range(255, 120));
      lo = 8'($urandom_range(60));
      case ($urandom_range(3))
        0: {it.ul, it.l, it.dl, it.ur, it.r, it.dr} = {lo, lo, lo, hi, hi, hi};
        1: {it.ul, it.l, it.dl, it.ur, it.r, it.dr} = {hi, hi, hi, lo, lo, lo};
        2: {it.ul, it.u, it.ur, it.dl, it.d, it.dr} = {lo, lo, lo, hi, hi, hi};
        default: {it.ul, it.u, it.ur, it.dl, it.d, it.dr} = {hi, hi, hi, lo, lo, lo};
      endcase
    end
    return it;
  endfunction

  // waits until the block is idle and every report has come
  task automatic drain();
    do @(negedge clk);
    while (pixel_q.size() != 0 || issued != taken || busy || report_q.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // random register setting, extremes often
  task automatic random_setting();
    int pick;
    pick = $urandom_range(5);
    write_reg(ghcv_pkg::REG_RADIUS,
              16'(pick == 0 ? 1 : pick == 1 ? 63 : $urandom_range(63)));
    pick = $urandom_range(5);
    write_reg(ghcv_pkg::REG_RANGE, 16'(pick == 0 ? 0 : pick == 1 ? 8 : pick == 2 ? 15
                                       : $urandom_range(15)));
    pick = $urandom_range(5);
    write_reg(ghcv_pkg::REG_MIN_CONF, 16'(pick == 0 ? 0 : pick == 1 ? 65535
                                          : pick == 2 ? 1 : $urandom_range(6)));
  endtask

  initial begin
    pixel_item_t keep;
    int count;
    rst_n = 0;
    start = 0;
    cfg_we = 0;
    cfg_index = ghcv_pkg::REG_RADIUS;
    cfg_data = 0;
    {in_mode, in_pixel_x, in_pixel_y, in_gray_up_left, in_gray_up, in_gray_up_right,
     in_gray_left, in_gray_right, in_gray_down_left, in_gray_down,
     in_gray_down_right} = '0;
    issued = 0;
    taken = 0;
    failed = 0;
    fill = 0;
    last_x = 0;
    last_y = 0;
    last_votes = 0;
    radius_reg = 13;
    range_reg = 3;
    min_conf_reg = 1;
    idle_pct = 21;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: empty frame at reset values repeats the cleared centre
    pixel_q.push_back(frame_end());
    // strongest edges at both image corners, all-dark pixel never votes
    pixel_q.push_back(vote_item(0, 0, 0, 0, 255, 0, 255, 0, 0, 255));
    pixel_q.push_back(vote_item(255, 255, 255, 255, 255, 0, 0, 0, 0, 0));
    pixel_q.push_back(vote_item(255, 255, 0, 0, 0, 0, 0, 0, 0, 0));
    // gradient just at the threshold, then just above it
    pixel_q.push_back(vote_item(100, 100, 0, 0, 0, 0, 100, 0, 0, 0));
    pixel_q.push_back(vote_item(100, 100, 0, 0, 1, 0, 100, 0, 0, 0));
    // diagonal edge, |Y| twice |X|, repeated for a second vote
    pixel_q.push_back(vote_item(40, 200, 255, 255, 255, 255, 0, 0, 0, 0));
    pixel_q.push_back(vote_item(40, 200, 255, 255, 255, 255, 0, 0, 0, 0));
    pixel_q.push_back(frame_end());
    drain();

    // empty table accepted only with zero confidence; negative and zero radii
    write_reg(ghcv_pkg::REG_MIN_CONF, 16'd0);
    pixel_q.push_back(frame_end());
    drain();
    write_reg(ghcv_pkg::REG_RADIUS, 16'd1);
    write_reg(ghcv_pkg::REG_RANGE, 16'd15);
    pixel_q.push_back(vote_item(3, 250, 0, 0, 0, 200, 0, 250, 90, 0));
    pixel_q.push_back(vote_item(128, 9, 0, 0, 255, 0, 255, 0, 255, 255));
    pixel_q.push_back(frame_end());
    drain();
    // range zero casts nothing; high confidence threshold repeats last centre
    write_reg(ghcv_pkg::REG_RANGE, 16'd0);
    write_reg(ghcv_pkg::REG_MIN_CONF, 16'd65535);
    pixel_q.push_back(vote_item(50, 50, 0, 0, 255, 0, 255, 0, 0, 255));
    pixel_q.push_back(frame_end());
    drain();

    // table full: distinct strong pixels overflow it, later pixels are dropped
    write_reg(ghcv_pkg::REG_RADIUS, 16'd20);
    write_reg(ghcv_pkg::REG_RANGE, 16'd8);
    write_reg(ghcv_pkg::REG_MIN_CONF, 16'd2);
    for (int i = 0; i < 36; i++)
      pixel_q.push_back(vote_item(i * 7, 255 - i * 5, 0, 30, 255, 0, 255, 0, 0, 255));
    pixel_q.push_back(frame_end());
    drain();

    // random frames: three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = ph == 0 ? 21 : ph == 1 ? 70 : 0;
      count = 0;
      while (count < 580) begin
        random_setting();
        keep = random_pixel();
        for (int j = $urandom_range(40, 3); j > 0; j--) begin
          // repeated pixels pile votes onto the same centres
          if ($urandom_range(99) < 30) pixel_q.push_back(keep);
          else begin
            keep = random_pixel();
            pixel_q.push_back(keep);
          end
          count++;
        end
        pixel_q.push_back(frame_end());
        count++;
        drain();
      end
    end

    if (!failed && report_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(64'd12 * 64'd40_000_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[files.f]
hdl/ghcv_pkg.sv
hdl/ghcv_offset.sv
hdl/ghcv_table.sv
hdl/gradient_hough_circle_voter.sv
hdl/ghcv_checker.sv
tb/gradient_hough_circle_voter_test.sv
